/* design/assert_macros.svh */
// assertion macros used by the splitter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/dlfs_pkg.sv */
// shared types, codes and helpers of the data list field splitter
package dlfs_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_UNTERMINATED = 3'd0;
  localparam logic [2:0] ERR_INVALID      = 3'd1;
  localparam logic [2:0] ERR_EMPTY        = 3'd2;
  localparam logic [2:0] ERR_UNEXPECTED   = 3'd3;
  localparam logic [2:0] ERR_SPACES       = 3'd4;

  // held space count field, wide enough for a space cap of up to 63
  localparam int SPC_W = 6;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // results of one beat, emitted in field order
  typedef struct packed {
    logic [SPC_W-1:0] nsp;
    logic             e1_v;
    logic [2:0]       e1_code;
    logic             c_v;
    logic [7:0]       c;
    logic             end1_v;
    logic             end1_q;
    logic             end1_done;
    logic             e2_v;
    logic             e3_v;
    logic [2:0]       e3_code;
    logic             end2_v;
    logic             end2_q;
    logic             end2_done;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic plain_char(input logic [7:0] c);
    logic ok;
    ok = (c == CH_SPACE) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_POINT) ||
         (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
         (c >= 8'h61 && c <= 8'h7A);
    return ok;
  endfunction

  function automatic logic cmd_live(input cmd_t m);
    logic live;
    live = (m.nsp != '0) || m.e1_v || m.c_v || m.end1_v || m.e2_v || m.e3_v || m.end2_v;
    return live;
  endfunction

endpackage

/* design/dlfs_if.sv */
// valid/ready channels of the splitter
interface dlfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       end_of_list;

  modport source(output valid, ch, has_char, end_of_list, input ready);
  modport sink(input valid, ch, has_char, end_of_list, output ready);
endinterface

interface dlfs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] text_char;
  logic       was_quoted;
  logic       list_done;
  logic [2:0] error_code;
  logic       last_result;

  modport source(output valid, kind, text_char, was_quoted, list_done, error_code,
                 last_result, input ready);
  modport sink(input valid, kind, text_char, was_quoted, list_done, error_code,
               last_result, output ready);
endinterface

/* design/dlfs_front.sv */
// front end: accepts characters, tracks the datum state, builds result commands
module dlfs_front import dlfs_pkg::*; #(
  parameter int MAX_PENDING_SPACES = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  dlfs_in_if.sink     in_chan,
  input  q_stat_t     q_stat,
  output logic        q_push,
  output cmd_t        q_cmd
);

  localparam int PW = $clog2(MAX_PENDING_SPACES + 1);
  localparam logic [PW-1:0] MAXP = PW'(MAX_PENDING_SPACES);

  localparam logic [2:0] M_LEAD    = 3'd0;
  localparam logic [2:0] M_QUOTED  = 3'd1;
  localparam logic [2:0] M_AFTERQ  = 3'd2;
  localparam logic [2:0] M_UNQ     = 3'd3;
  localparam logic [2:0] M_STOPPED = 3'd4;

  logic [2:0]    mode_r, mode_nxt;
  logic [PW-1:0] pend_r, pend_nxt;
  logic          accept;
  logic [7:0]    c;

  assign c              = in_chan.ch;
  assign in_chan.ready  = !q_stat.full;
  assign accept         = in_chan.valid && in_chan.ready;
  assign q_push         = accept && cmd_live(q_cmd);

  always_comb begin
    q_cmd    = '0;
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    if (in_chan.has_char) begin
      unique case (mode_r)
        M_LEAD: begin
          if (c == CH_QUOTE) begin
            mode_nxt = M_QUOTED;
          end else if (c == CH_COMMA) begin
            q_cmd.e1_v    = 1'b1;
            q_cmd.e1_code = ERR_EMPTY;
            q_cmd.end1_v  = 1'b1;
          end else if (c != CH_SPACE) begin
            q_cmd.e1_v    = !plain_char(c);
            q_cmd.e1_code = ERR_INVALID;
            q_cmd.c_v     = 1'b1;
            q_cmd.c       = c;
            pend_nxt      = '0;
            mode_nxt      = M_UNQ;
          end
        end
        M_QUOTED: begin
          if (c == CH_QUOTE) begin
            mode_nxt = M_AFTERQ;
          end else begin
            q_cmd.c_v = 1'b1;
            q_cmd.c   = c;
          end
        end
        M_AFTERQ: begin
          if (c == CH_COMMA) begin
            q_cmd.end1_v = 1'b1;
            q_cmd.end1_q = 1'b1;
            mode_nxt     = M_LEAD;
          end else if (c != CH_SPACE) begin
            // junk after the closing quote ends the list early
            q_cmd.end1_v    = 1'b1;
            q_cmd.end1_q    = 1'b1;
            q_cmd.end1_done = 1'b1;
            q_cmd.e2_v      = 1'b1;
            mode_nxt        = M_STOPPED;
          end
        end
        M_UNQ: begin
          if (c == CH_SPACE) begin
            if (pend_r >= MAXP) begin
              q_cmd.e1_v    = 1'b1;
              q_cmd.e1_code = ERR_SPACES;
            end else begin
              pend_nxt = pend_r + 1'b1;
            end
          end else if (c == CH_COMMA) begin
            pend_nxt     = '0;
            q_cmd.end1_v = 1'b1;
            mode_nxt     = M_LEAD;
          end else begin
            // held spaces go out ahead of the character
            q_cmd.nsp     = SPC_W'(pend_r);
            pend_nxt      = '0;
            q_cmd.e1_v    = !plain_char(c);
            q_cmd.e1_code = ERR_INVALID;
            q_cmd.c_v     = 1'b1;
            q_cmd.c       = c;
          end
        end
        M_STOPPED: begin
        end
        default: begin
        end
      endcase
    end
    if (in_chan.end_of_list) begin
      unique case (mode_nxt)
        M_LEAD: begin
          q_cmd.e3_v      = 1'b1;
          q_cmd.e3_code   = ERR_EMPTY;
          q_cmd.end2_v    = 1'b1;
          q_cmd.end2_done = 1'b1;
        end
        M_QUOTED: begin
          q_cmd.e3_v      = 1'b1;
          q_cmd.e3_code   = ERR_UNTERMINATED;
          q_cmd.end2_v    = 1'b1;
          q_cmd.end2_q    = 1'b1;
          q_cmd.end2_done = 1'b1;
        end
        M_AFTERQ: begin
          q_cmd.end2_v    = 1'b1;
          q_cmd.end2_q    = 1'b1;
          q_cmd.end2_done = 1'b1;
        end
        M_UNQ: begin
          q_cmd.end2_v    = 1'b1;
          q_cmd.end2_done = 1'b1;
        end
        M_STOPPED: begin
        end
        default: begin
        end
      endcase
      mode_nxt = M_LEAD;
      pend_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_LEAD;
      pend_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

/* design/dlfs_queue.sv */
// command queue between the front and back ends
module dlfs_queue import dlfs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    wr_cmd,
  input  logic    pop,
  output cmd_t    rd_cmd,
  output q_stat_t stat
);

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign rd_cmd     = q_mem[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* design/dlfs_back.sv */
// back end: expands one command into result beats, one per cycle while the output is not stalled
module dlfs_back import dlfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_t     q_head,
  input  q_stat_t  q_stat,
  output logic     q_pop,
  dlfs_out_if.source out_chan
);

  cmd_t       cur_r, cur_nxt, rem;
  logic       busy_r, busy_nxt;
  logic       adv, last;

  logic       ov_r;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] tc_r, tc_nxt;
  logic       q_r, q_nxt;
  logic       done_r, done_nxt;
  logic [2:0] err_r, err_nxt;
  logic       last_r;

  // pick the first outstanding result of the current command
  always_comb begin
    rem      = cur_r;
    kind_nxt = KIND_CHAR;
    tc_nxt   = '0;
    q_nxt    = 1'b0;
    done_nxt = 1'b0;
    err_nxt  = '0;
    priority if (cur_r.nsp != '0) begin
      tc_nxt  = CH_SPACE;
      rem.nsp = cur_r.nsp - 1'b1;
    end else if (cur_r.e1_v) begin
      kind_nxt = KIND_ERR;
      err_nxt  = cur_r.e1_code;
      rem.e1_v = 1'b0;
    end else if (cur_r.c_v) begin
      tc_nxt  = cur_r.c;
      rem.c_v = 1'b0;
    end else if (cur_r.end1_v) begin
      kind_nxt   = KIND_END;
      q_nxt      = cur_r.end1_q;
      done_nxt   = cur_r.end1_done;
      rem.end1_v = 1'b0;
    end else if (cur_r.e2_v) begin
      kind_nxt = KIND_ERR;
      err_nxt  = ERR_UNEXPECTED;
      rem.e2_v = 1'b0;
    end else if (cur_r.e3_v) begin
      kind_nxt = KIND_ERR;
      err_nxt  = cur_r.e3_code;
      rem.e3_v = 1'b0;
    end else begin
      kind_nxt   = KIND_END;
      q_nxt      = cur_r.end2_q;
      done_nxt   = cur_r.end2_done;
      rem.end2_v = 1'b0;
    end
  end

  assign last  = !cmd_live(rem);
  assign adv   = busy_r && (!ov_r || out_chan.ready);
  assign q_pop = !q_stat.empty && (!busy_r || (adv && last));

  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    if (q_pop) begin
      cur_nxt  = q_head;
      busy_nxt = 1'b1;
    end else if (adv) begin
      cur_nxt  = rem;
      busy_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (adv) begin
        ov_r <= 1'b1;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (adv) begin
      kind_r <= kind_nxt;
      tc_r   <= tc_nxt;
      q_r    <= q_nxt;
      done_r <= done_nxt;
      err_r  <= err_nxt;
      last_r <= last;
    end
  end

  assign out_chan.valid       = ov_r;
  assign out_chan.kind        = kind_r;
  assign out_chan.text_char   = tc_r;
  assign out_chan.was_quoted  = q_r;
  assign out_chan.list_done   = done_r;
  assign out_chan.error_code  = err_r;
  assign out_chan.last_result = last_r;

endmodule

/* design/data_list_field_splitter.sv */
// top level of the data list field splitter
// Takes one character of a comma-separated list per beat and returns datum
// characters, datum ends and error beats, with last_result marking the final
// result of each input beat. A character is accepted every cycle while the
// 4-entry command queue has room; the back end sends one result per cycle
// while out_chan is ready, and a beat has up to MAX_PENDING_SPACES + 3
// results when held spaces are flushed, so a long burst backs the queue up
// into in_chan.ready. The first result of a beat passes through the command
// queue, the back end's current-command register and its output registers.
`include "assert_macros.svh"

module data_list_field_splitter import dlfs_pkg::*; #(
  parameter int MAX_PENDING_SPACES = 30
) (
  input  logic       clk,
  input  logic       rst_n,
  dlfs_in_if.sink    in_chan,
  dlfs_out_if.source out_chan
);

  cmd_t    q_wr_cmd, q_rd_cmd;
  q_stat_t q_stat;
  logic    q_push, q_pop;

  dlfs_front #(
    .MAX_PENDING_SPACES(MAX_PENDING_SPACES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_cmd   (q_wr_cmd)
  );

  dlfs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .pop    (q_pop),
    .rd_cmd (q_rd_cmd),
    .stat   (q_stat)
  );

  dlfs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_rd_cmd),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  `ASSERT_IMPLIES(a_push_has_room, clk, rst_n, q_push, !q_stat.full)
  `ASSERT_IMPLIES(a_pop_has_entry, clk, rst_n, q_pop, !q_stat.empty)
  `ASSERT_NEXT(a_pop_frees_slot, clk, rst_n, q_pop && !q_push, !q_stat.full)
  `ASSERT_IMPLIES(a_kind_legal, clk, rst_n, out_chan.valid, out_chan.kind <= KIND_ERR)

endmodule

/* tb/tb_top.sv */
// testbench top: feeds character lists into the splitter and checks every result beat
`timescale 1ns / 100ps

module tb_top import dlfs_pkg::*; ();

  localparam int SPACE_CAP = 30;

  typedef enum logic [2:0] {
    SPL_LEAD,
    SPL_QUOTED,
    SPL_AFTERQ,
    SPL_UNQ,
    SPL_STOPPED
  } split_mode_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text_char;
    logic       was_quoted;
    logic       list_done;
    logic [2:0] error_code;
    logic       last_result;
  } split_result_t;

  logic clk = 1'b0;
  logic rst_n;

  dlfs_in_if  in_chan();
  dlfs_out_if out_chan();

  data_list_field_splitter #(
    .MAX_PENDING_SPACES(SPACE_CAP)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always #6 clk = ~clk;

  split_result_t expected_results[$];
  split_result_t head_result;
  split_mode_e   split_mode;
  int            held_spaces;
  int            err_count = 0;
  int            data_beats = 0;
  bit            src_idle_en = 1'b1;
  bit            snk_idle_en = 1'b1;
  logic [7:0]    list_text[$];

  // ---------------- datum predictor ----------------

  function automatic logic is_plain_char(input logic [7:0] c);
    return c inside {CH_SPACE, CH_PLUS, CH_MINUS, CH_POINT,
                     [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic void add_result(input logic [1:0] kind, input logic [7:0] tc,
                                     input logic q, input logic done,
                                     input logic [2:0] code);
    split_result_t r;
    r.kind        = kind;
    r.text_char   = tc;
    r.was_quoted  = q;
    r.list_done   = done;
    r.error_code  = code;
    r.last_result = 1'b0;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void predict_char(input logic [7:0] c);
    unique case (split_mode)
      SPL_LEAD: begin
        if (c == CH_QUOTE) begin
          split_mode = SPL_QUOTED;
        end else if (c == CH_COMMA) begin
          add_result(KIND_ERR, 8'h00, 1'b0, 1'b0, ERR_EMPTY);
          add_result(KIND_END, 8'h00, 1'b0, 1'b0, ERR_UNTERMINATED);
        end else if (c != CH_SPACE) begin
          if (!is_plain_char(c)) add_result(KIND_ERR, 8'h00, 1'b0, 1'b0, ERR_INVALID);
          add_result(KIND_CHAR, c, 1'b0, 1'b0, ERR_UNTERMINATED);
          held_spaces = 0;
          split_mode  = SPL_UNQ;
        end
      end
      SPL_QUOTED: begin
        if (c == CH_QUOTE) split_mode = SPL_AFTERQ;
        else add_result(KIND_CHAR, c, 1'b0, 1'b0, ERR_UNTERMINATED);
      end
      SPL_AFTERQ: begin
        if (c == CH_COMMA) begin
          add_result(KIND_END, 8'h00, 1'b1, 1'b0, ERR_UNTERMINATED);
          split_mode = SPL_LEAD;
        end else if (c != CH_SPACE) begin
          // junk after the closing quote stops the split
          add_result(KIND_END, 8'h00, 1'b1, 1'b1, ERR_UNTERMINATED);
          add_result(KIND_ERR, 8'h00, 1'b0, 1'b0, ERR_UNEXPECTED);
          split_mode = SPL_STOPPED;
        end
      end
      SPL_UNQ: begin
        if (c == CH_SPACE) begin
          if (held_spaces >= SPACE_CAP) add_result(KIND_ERR, 8'h00, 1'b0, 1'b0, ERR_SPACES);
          else held_spaces++;
        end else if (c == CH_COMMA) begin
          held_spaces = 0;
          add_result(KIND_END, 8'h00, 1'b0, 1'b0, ERR_UNTERMINATED);
          split_mode = SPL_LEAD;
        end else begin
          while (held_spaces > 0) begin
            add_result(KIND_CHAR, CH_SPACE, 1'b0, 1'b0, ERR_UNTERMINATED);
            held_spaces--;
          end
          if (!is_plain_char(c)) add_result(KIND_ERR, 8'h00, 1'b0, 1'b0, ERR_INVALID);
          add_result(KIND_CHAR, c, 1'b0, 1'b0, ERR_UNTERMINATED);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_list_end();
    unique case (split_mode)
      SPL_LEAD: begin
        add_result(KIND_ERR, 8'h00, 1'b0, 1'b0, ERR_EMPTY);
        add_result(KIND_END, 8'h00, 1'b0, 1'b1, ERR_UNTERMINATED);
      end
      SPL_QUOTED: begin
        add_result(KIND_ERR, 8'h00, 1'b0, 1'b0, ERR_UNTERMINATED);
        add_result(KIND_END, 8'h00, 1'b1, 1'b1, ERR_UNTERMINATED);
      end
      SPL_AFTERQ: add_result(KIND_END, 8'h00, 1'b1, 1'b1, ERR_UNTERMINATED);
      SPL_UNQ:    add_result(KIND_END, 8'h00, 1'b0, 1'b1, ERR_UNTERMINATED);
      default: ;
    endcase
    split_mode  = SPL_LEAD;
    held_spaces = 0;
  endfunction

  function automatic void predict_beat(input logic [7:0] c, input logic has,
                                       input logic eol);
    int            first;
    split_result_t r;
    first = expected_results.size();
    if (has) predict_char(c);
    if (eol) predict_list_end();
    if (expected_results.size() > first) begin
      r = expected_results[expected_results.size() - 1];
      r.last_result = 1'b1;
      expected_results[expected_results.size() - 1] = r;
    end
  endfunction

  // ---------------- result checking ----------------

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", out_chan.kind);
        err_count++;
      end else begin
        head_result = expected_results.pop_front();
        check_field("kind", 8'(head_result.kind), 8'(out_chan.kind));
        check_field("text_char", head_result.text_char, out_chan.text_char);
        check_field("was_quoted", 8'(head_result.was_quoted), 8'(out_chan.was_quoted));
        check_field("list_done", 8'(head_result.list_done), 8'(out_chan.list_done));
        check_field("error_code", 8'(head_result.error_code), 8'(out_chan.error_code));
        check_field("last_result", 8'(head_result.last_result), 8'(out_chan.last_result));
      end
    end
  end

  // result side: random stall before each beat while snk_idle_en is set
  initial begin : result_sink
    int stall;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = snk_idle_en ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_beat(input logic [7:0] c, input logic has, input logic eol);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.ch          <= c;
    in_chan.has_char    <= has;
    in_chan.end_of_list <= eol;
    do @(posedge clk); while (!in_chan.ready);
    predict_beat(c, has, eol);
    if (has || eol) data_beats++;
  endtask

  task automatic wait_all_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // sends list_text, with the list end on the last character or in a beat of its own
  task automatic play_list(input bit end_alone);
    for (int i = 0; i < list_text.size(); i++) begin
      if ($urandom_range(0, 15) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(list_text[i], 1'b1, !end_alone && (i == list_text.size() - 1));
    end
    if (end_alone || list_text.size() == 0)
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] pick_plain();
    int r;
    r = $urandom_range(0, 64);
    if (r < 26) return 8'h41 + 8'(r);
    if (r < 52) return 8'h61 + 8'(r - 26);
    if (r < 62) return 8'h30 + 8'(r - 52);
    if (r == 62) return CH_PLUS;
    if (r == 63) return CH_MINUS;
    return CH_POINT;
  endfunction

  function automatic void add_text(input logic [7:0] b);
    list_text.insert(list_text.size(), b);
  endfunction

  function automatic void add_spaces(input int n);
    repeat (n) add_text(CH_SPACE);
  endfunction

  function automatic void add_unquoted();
    int         len;
    logic [7:0] b;
    add_spaces($urandom_range(0, 2));
    b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : pick_plain();
    if (b == CH_COMMA || b == CH_QUOTE || b == CH_SPACE) b = b ^ 8'h80;
    add_text(b);
    len = $urandom_range(0, 5);
    repeat (len) begin
      case ($urandom_range(0, 9))
        0: add_spaces($urandom_range(1, 3));
        1: add_spaces(($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : 1);
        2: begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_COMMA) b = 8'hAC;
          add_text(b);
        end
        default: add_text(pick_plain());
      endcase
    end
    add_spaces($urandom_range(0, 3));
  endfunction

  function automatic void add_quoted(input bit is_last);
    int         len;
    int         tail;
    logic [7:0] b;
    add_spaces($urandom_range(0, 2));
    add_text(CH_QUOTE);
    len = $urandom_range(0, 6);
    repeat (len) begin
      case ($urandom_range(0, 5))
        0: b = 8'($urandom_range(0, 255));
        1: b = CH_SPACE;
        2: b = CH_COMMA;
        default: b = pick_plain();
      endcase
      if (b == CH_QUOTE) b = 8'h27;
      add_text(b);
    end
    tail = $urandom_range(0, 9);
    // missing closing quote only on the final datum
    if (is_last && tail == 0) return;
    add_text(CH_QUOTE);
    add_spaces($urandom_range(0, 2));
    if (tail == 1) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_SPACE || b == CH_COMMA) b = 8'h21;
      add_text(b);
      repeat ($urandom_range(0, 3)) add_text(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic build_random_list();
    int n;
    list_text.delete();
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(0, 8);
      repeat (n) add_text(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if (i > 0) add_text(CH_COMMA);
        case ($urandom_range(0, 9))
          0:       add_spaces($urandom_range(0, 2));
          1, 2, 3: add_quoted(i == n - 1);
          default: add_unquoted();
        endcase
      end
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_directed_lists();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    send_beat(8'h00, 1'b0, 1'b1);  // empty list
    send_beat(8'hFF, 1'b0, 1'b0);  // idle beat
    // quoted datum keeping space and comma, spaces after the quote, then empty datum
    list_text = {CH_SPACE, CH_QUOTE, 8'h41, CH_SPACE, CH_COMMA, CH_QUOTE,
                 CH_SPACE, CH_SPACE, CH_COMMA};
    play_list(1'b1);
    send_beat(CH_COMMA, 1'b1, 1'b1);
    // invalid extremes, held space flushed, trailing space dropped
    list_text = {8'h00, CH_SPACE, 8'hFF, CH_SPACE, CH_COMMA, 8'h39};
    play_list(1'b0);
    list_text = {CH_QUOTE, 8'h62};  // missing closing quote
    play_list(1'b0);
    list_text = {CH_QUOTE, CH_QUOTE, 8'h78, 8'h79};  // junk after quote
    play_list(1'b1);
    list_text = {CH_QUOTE, 8'h7A, CH_QUOTE};
    play_list(1'b0);
  endtask

  task automatic test_space_cap();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b1;
    // over the cap, then an invalid char closing the list: the largest burst
    list_text = {8'h78};
    add_spaces(SPACE_CAP + 3);
    add_text(8'h7F);
    play_list(1'b0);
    list_text = {8'h6B};
    add_spaces(SPACE_CAP);
    add_text(8'h6D);
    add_text(CH_COMMA);
    add_text(8'h70);
    add_spaces(SPACE_CAP + 5);
    add_text(CH_COMMA);
    play_list(1'b1);
  endtask

  task automatic test_pause_for_results();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    list_text = {8'h71, CH_COMMA, CH_QUOTE, 8'h72, CH_QUOTE};
    play_list(1'b0);
    wait_all_results();
    list_text = {8'h2D, 8'h2B, CH_POINT};
    play_list(1'b1);
  endtask

  task automatic test_random_lists();
    int target;
    int lists;
    // the directed tests already sent part of the run's items
    target = 300;
    lists  = 0;
    while (data_beats < target) begin
      src_idle_en = ($urandom_range(0, 3) != 0);
      snk_idle_en = ($urandom_range(0, 3) != 0);
      build_random_list();
      play_list($urandom_range(0, 2) == 0);
      lists++;
      if (lists % 12 == 0) wait_all_results();
    end
  endtask

  initial begin
    in_chan.valid       <= 1'b0;
    in_chan.ch          <= 8'h00;
    in_chan.has_char    <= 1'b0;
    in_chan.end_of_list <= 1'b0;
    rst_n               <= 1'b0;
    split_mode  = SPL_LEAD;
    held_spaces = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_lists();
    test_space_cap();
    test_pause_for_results();
    test_random_lists();
    wait_all_results();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* data_list_field_splitter.f */
+incdir+design
design/dlfs_pkg.sv
design/dlfs_if.sv
design/dlfs_front.sv
design/dlfs_queue.sv
design/dlfs_back.sv
design/data_list_field_splitter.sv
tb/tb_top.sv
